FILE: design/sist_pkg.sv
package sist_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ID_WIDTH    = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_SORT   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_READ   = 3'd5,
    CMD_NOP6   = 3'd6,
    CMD_NOP7   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NOT_SORTED = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_FIND_RD,
    S_FIND_CMP,
    S_FIND_CHK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SORT_KEY,
    S_SORT_LD,
    S_SORT_RD,
    S_SORT_CMP,
    S_DONE
  } state_t;

endpackage

FILE: design/sorted_id_set_table_core.sv
// Table of up to 64 unsigned IDs in one RAM with a registered read, one
// command per word and one result word per command. Add, clear, unused codes
// and find on an unsorted table go straight to the result; read fetches the
// indexed entry first; find is a binary search that reads and compares one
// probe per step, plus a final check of the lower bound; remove scans the
// entries for the first match and then shifts the later entries down one by
// one; sort is an insertion sort that loads each key and moves the larger
// entries before it up one place at a time. The registered RAM read sets the
// pace of every read step. The result moves to an output register as soon as
// that register is free, and the next word is taken in the cycle after.
module sorted_id_set_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], id_value[34:3], entry_index[40:35], zero pad to 48
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], found[3], found_index[9:4], entry_value[41:10],
  // entry_count[48:42], zero pad to 56
  output logic [55:0] out_tdata
);
  import sist_pkg::*;

  state_t state_r, state_nxt;
  logic [ID_WIDTH-1:0] id_r;
  logic [5:0]          idx_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                srt_r, srt_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [ID_WIDTH-1:0] key_r, key_nxt;
  logic [2:0]          st_r, st_nxt;
  logic                fnd_r, fnd_nxt;
  logic [5:0]          fidx_r, fidx_nxt;
  logic [31:0]         val_r, val_nxt;
  logic                ov_r;
  logic [55:0]         od_r;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [ID_WIDTH-1:0] wdata, rdata;
  logic [CNT_W-1:0]    mid;
  logic                accept;
  logic                load_out;

  sist_ram #(.WIDTH(ID_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign load_out   = (state_r == S_DONE) && (!ov_r || out_tready);

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        unique case (cmd_t'(in_tdata[2:0]))
          CMD_REMOVE: state_nxt = S_SCAN_RD;
          CMD_FIND:   state_nxt = srt_r ? S_FIND_RD : S_DONE;
          CMD_SORT:   state_nxt = S_SORT_KEY;
          CMD_READ:   state_nxt = S_READ;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_READ:     state_nxt = S_DONE;
      S_FIND_RD: begin
        if (lo_r < hi_r) state_nxt = S_FIND_CMP;
        else if (lo_r < cnt_r) state_nxt = S_FIND_CHK;
        else state_nxt = S_DONE;
      end
      S_FIND_CMP: state_nxt = S_FIND_RD;
      S_FIND_CHK: state_nxt = S_DONE;
      S_SCAN_RD:  state_nxt = (i_r >= cnt_r) ? S_DONE : S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = (rdata == id_r) ? S_SHIFT_RD : S_SCAN_RD;
      S_SHIFT_RD: state_nxt = ((i_r + 1'b1) >= cnt_r) ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_SORT_KEY: state_nxt = (i_r >= cnt_r) ? S_DONE : S_SORT_LD;
      S_SORT_LD:  state_nxt = S_SORT_RD;
      S_SORT_RD:  state_nxt = (j_r == '0) ? S_SORT_KEY : S_SORT_CMP;
      S_SORT_CMP: state_nxt = (rdata > key_r) ? S_SORT_RD : S_SORT_KEY;
      S_DONE:     if (!ov_r || out_tready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory port
  always_comb begin
    cnt_nxt = cnt_r; srt_nxt = srt_r; lo_nxt = lo_r; hi_nxt = hi_r;
    i_nxt = i_r; j_nxt = j_r; key_nxt = key_r;
    st_nxt = st_r; fnd_nxt = fnd_r; fidx_nxt = fidx_r; val_nxt = val_r;
    we = 1'b0; waddr = j_r[ADDR_W-1:0]; wdata = key_r; raddr = i_r[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: if (accept) begin
        st_nxt = ST_OK; fnd_nxt = 1'b0; fidx_nxt = '0; val_nxt = '0;
        i_nxt = '0; lo_nxt = '0; hi_nxt = cnt_r;
        raddr = in_tdata[35 +: ADDR_W];
        unique case (cmd_t'(in_tdata[2:0]))
          CMD_ADD: begin
            if (cnt_r >= CNT_W'(TABLE_DEPTH)) st_nxt = ST_FULL;
            else begin
              we = 1'b1; waddr = cnt_r[ADDR_W-1:0];
              wdata = in_tdata[3 +: ID_WIDTH];
              cnt_nxt = cnt_r + 1'b1; srt_nxt = 1'b0;
            end
          end
          CMD_FIND: if (!srt_r) st_nxt = ST_NOT_SORTED;
          CMD_SORT: i_nxt = CNT_W'(1);
          CMD_CLEAR: begin cnt_nxt = '0; srt_nxt = 1'b1; end
          default: ;
        endcase
      end
      S_READ: begin
        if ({1'b0, idx_r} >= cnt_r) st_nxt = ST_RANGE;
        else val_nxt = 32'(rdata);
      end
      // Probe the middle entry, or fetch the lower bound once the range closes
      S_FIND_RD: begin
        raddr = (lo_r < hi_r) ? mid[ADDR_W-1:0] : lo_r[ADDR_W-1:0];
        if (lo_r >= hi_r && lo_r >= cnt_r) st_nxt = ST_NOT_FOUND;
      end
      S_FIND_CMP: begin
        if (rdata < id_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
      end
      S_FIND_CHK: begin
        if (rdata == id_r) begin
          fnd_nxt = 1'b1; fidx_nxt = lo_r[5:0];
        end else st_nxt = ST_NOT_FOUND;
      end
      // Scan for the first match
      S_SCAN_RD: begin
        if (i_r >= cnt_r) st_nxt = ST_NOT_FOUND;
      end
      S_SCAN_CMP: begin
        if (rdata != id_r) i_nxt = i_r + 1'b1;
      end
      // Move each later entry down by one
      S_SHIFT_RD: begin
        raddr = ADDR_W'(i_r + 1'b1);
        if ((i_r + 1'b1) >= cnt_r) cnt_nxt = cnt_r - 1'b1;
      end
      S_SHIFT_WR: begin
        we = 1'b1; waddr = i_r[ADDR_W-1:0]; wdata = rdata;
        i_nxt = i_r + 1'b1;
      end
      // Insertion sort: load key i, walk down while the left entry is larger
      S_SORT_KEY: begin
        j_nxt = i_r;
        if (i_r >= cnt_r) srt_nxt = 1'b1;
      end
      S_SORT_LD: key_nxt = rdata;
      S_SORT_RD: begin
        raddr = ADDR_W'(j_r - 1'b1);
        if (j_r == '0) begin
          we = 1'b1;
          i_nxt = i_r + 1'b1;
        end
      end
      S_SORT_CMP: begin
        we = 1'b1;
        if (rdata > key_r) begin
          wdata = rdata; j_nxt = j_r - 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; cnt_r <= '0; srt_r <= 1'b1;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; srt_r <= srt_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; i_r <= i_nxt; j_r <= j_nxt; key_r <= key_nxt;
    st_r <= st_nxt; fnd_r <= fnd_nxt; fidx_r <= fidx_nxt; val_r <= val_nxt;
    if (accept) begin
      id_r  <= in_tdata[3 +: ID_WIDTH];
      idx_r <= in_tdata[35 +: 6];
    end
    if (load_out) begin
      od_r <= {7'd0, cnt_r, val_r, fidx_r, fnd_r, st_r};
    end
  end

  // Hold the result word until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata));

  // Keep the count within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH));

  // Take words only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE);

  // Report only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_RANGE);

endmodule

FILE: design/sist_ram.sv
module sist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/sorted_id_set_table_core_test.sv
`timescale 1ns / 1ps

module sorted_id_set_table_core_test;
  import sist_pkg::*;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic [31:0] id_value;
    logic [2:0]  command;
  } id_cmd_t;

  typedef struct packed {
    logic [6:0]  entry_count;
    logic [31:0] entry_value;
    logic [5:0]  found_index;
    logic        found;
    logic [2:0]  status;
  } id_rsp_t;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  id_cmd_t cmd_queue[$];
  id_rsp_t rsp_expected[$];

  // shadow of the table
  logic [31:0] shadow_ids[TABLE_DEPTH];
  int          shadow_count;
  bit          shadow_sorted;

  int  fail_count;
  int  send_wait;
  int  recv_wait;
  int  hold_off;
  int  idle_cycles;
  bit  stim_done;
  bit  hold_armed;
  int  words_out;

  sorted_id_set_table_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // compute the response word and update the shadow table
  function automatic id_rsp_t apply_table_cmd(id_cmd_t c);
    id_rsp_t r;
    int i;
    int lo;
    int hi;
    int mid;
    logic [31:0] key;
    r = '0;
    r.status = ST_OK;
    case (cmd_t'(c.command))
      CMD_ADD: begin
        if (shadow_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_ids[shadow_count] = c.id_value;
          shadow_count++;
          shadow_sorted = 1'b0;
        end
      end
      CMD_REMOVE: begin
        for (i = 0; i < shadow_count; i++)
          if (shadow_ids[i] == c.id_value) break;
        if (i >= shadow_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (; i + 1 < shadow_count; i++) shadow_ids[i] = shadow_ids[i + 1];
          shadow_count--;
        end
      end
      CMD_FIND: begin
        if (!shadow_sorted) begin
          r.status = ST_NOT_SORTED;
        end else begin
          lo = 0;
          hi = shadow_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_ids[mid] < c.id_value) lo = mid + 1;
            else hi = mid;
          end
          if (lo < shadow_count && shadow_ids[lo] == c.id_value) begin
            r.found = 1'b1;
            r.found_index = lo[5:0];
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
      end
      CMD_SORT: begin
        for (i = 1; i < shadow_count; i++) begin
          key = shadow_ids[i];
          mid = i;
          while (mid > 0 && shadow_ids[mid - 1] > key) begin
            shadow_ids[mid] = shadow_ids[mid - 1];
            mid--;
          end
          shadow_ids[mid] = key;
        end
        shadow_sorted = 1'b1;
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        shadow_sorted = 1'b1;
      end
      CMD_READ: begin
        if (c.entry_index >= shadow_count) r.status = ST_RANGE;
        else r.entry_value = shadow_ids[c.entry_index];
      end
      default: ;
    endcase
    r.entry_count = shadow_count[6:0];
    return r;
  endfunction

  function automatic id_cmd_t make_cmd(cmd_t op, logic [31:0] id, logic [5:0] idx);
    id_cmd_t c;
    c.command = op;
    c.id_value = id;
    c.entry_index = idx;
    return c;
  endfunction

  // append one command to the pending queue
  function automatic void enqueue_cmd(cmd_t op, logic [31:0] id, logic [5:0] idx);
    cmd_queue.insert(cmd_queue.size(), make_cmd(op, id, idx));
  endfunction

  // random ID, often drawn from a small pool so removes and finds hit
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return 32'(($urandom_range(0, 23)) * 32'h1111_1111 ^ 32'h8000_0001);
    endcase
  endfunction

  // fill the command queue
  initial begin
    int n;
    int k;
    int fill;
    // directed: empty cases, extremes, unused codes, full table
    enqueue_cmd(CMD_FIND, 32'h0, 6'd0);
    enqueue_cmd(CMD_READ, 32'h0, 6'd0);
    enqueue_cmd(CMD_REMOVE, 32'h5, 6'd0);
    enqueue_cmd(CMD_ADD, 32'hFFFF_FFFF, 6'd63);
    enqueue_cmd(CMD_ADD, 32'h0, 6'd0);
    enqueue_cmd(CMD_ADD, 32'h8000_0000, 6'd0);
    enqueue_cmd(CMD_ADD, 32'h0, 6'd0);
    enqueue_cmd(CMD_FIND, 32'h0, 6'd0);
    enqueue_cmd(CMD_SORT, 32'hFFFF_FFFF, 6'd63);
    enqueue_cmd(CMD_FIND, 32'h0, 6'd0);
    enqueue_cmd(CMD_FIND, 32'hFFFF_FFFF, 6'd0);
    enqueue_cmd(CMD_FIND, 32'h1234, 6'd0);
    enqueue_cmd(CMD_READ, 32'h0, 6'd3);
    enqueue_cmd(CMD_READ, 32'h0, 6'd4);
    enqueue_cmd(CMD_READ, 32'hFFFF_FFFF, 6'd63);
    enqueue_cmd(CMD_REMOVE, 32'h0, 6'd0);
    enqueue_cmd(CMD_REMOVE, 32'h7777, 6'd0);
    enqueue_cmd(CMD_NOP6, 32'hFFFF_FFFF, 6'd63);
    enqueue_cmd(CMD_NOP7, 32'h0, 6'd0);
    enqueue_cmd(CMD_CLEAR, 32'h0, 6'd0);
    for (k = 0; k < TABLE_DEPTH + 1; k++)
      enqueue_cmd(CMD_ADD, $urandom(), 6'd0);
    enqueue_cmd(CMD_SORT, 32'h0, 6'd0);
    enqueue_cmd(CMD_READ, 32'h0, 6'd63);
    // random: add bursts, mostly short, then sort/find/read/remove/add/unused-code mixes
    n = 0;
    while (n < 1360) begin
      fill = $urandom_range(0, 9) == 0 ? 40 : $urandom_range(1, 10);
      for (k = 0; k < fill; k++) begin
        enqueue_cmd(CMD_ADD, pick_id(), 6'($urandom()));
        n++;
      end
      if ($urandom_range(0, 3) != 0) begin
        enqueue_cmd(CMD_SORT, $urandom(), 6'($urandom()));
        n++;
      end
      for (k = 0; k < $urandom_range(2, 12); k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: enqueue_cmd(CMD_FIND, pick_id(), 6'($urandom()));
          3, 4: enqueue_cmd(CMD_READ, $urandom(),
                            $urandom_range(0, 1) ? 6'($urandom_range(0, 15))
                                                 : 6'($urandom()));
          5, 6: enqueue_cmd(CMD_REMOVE, pick_id(), 6'($urandom()));
          7: enqueue_cmd(CMD_ADD, pick_id(), 6'($urandom()));
          8: enqueue_cmd(cmd_t'(3'($urandom_range(6, 7))), $urandom(),
                         6'($urandom()));
          default: enqueue_cmd(CMD_SORT, $urandom(), 6'($urandom()));
        endcase
        n++;
      end
      if ($urandom_range(0, 7) == 0) begin
        enqueue_cmd(CMD_CLEAR, $urandom(), 6'($urandom()));
        n++;
      end
    end
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: offer words from the queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_wait <= 0;
      stim_done <= 1'b0;
      shadow_count = 0;
      shadow_sorted = 1'b1;
    end else begin
      if (in_tvalid && in_tready) begin
        rsp_expected.insert(rsp_expected.size(),
                            apply_table_cmd(id_cmd_t'(in_tdata[40:0])));
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          in_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (cmd_queue.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, cmd_queue.pop_front()};
          send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          in_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor: random stalls, one long hold-off, compare each word
  always @(posedge clk) begin
    id_rsp_t got;
    id_rsp_t exp;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait <= 0;
      hold_off <= 0;
      hold_armed <= 1'b1;
      words_out <= 0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = id_rsp_t'(out_tdata[48:0]);
        words_out <= words_out + 1;
        if (rsp_expected.size() == 0) begin
          $error("unexpected word %h", out_tdata);
          fail_count++;
        end else begin
          exp = rsp_expected.pop_front();
          if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status);
            fail_count++;
          end
          if (got.found !== exp.found) begin
            $error("found exp %0d got %0d", exp.found, got.found);
            fail_count++;
          end
          if (got.found_index !== exp.found_index) begin
            $error("found_index exp %0d got %0d", exp.found_index, got.found_index);
            fail_count++;
          end
          if (got.entry_value !== exp.entry_value) begin
            $error("entry_value exp %h got %h", exp.entry_value, got.entry_value);
            fail_count++;
          end
          if (got.entry_count !== exp.entry_count) begin
            $error("entry_count exp %0d got %0d", exp.entry_count, got.entry_count);
            fail_count++;
          end
        end
      end
      if (hold_armed && words_out == 300) begin
        hold_armed <= 1'b0;
        hold_off <= 400;
        out_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready)
          recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (!(stim_done && rsp_expected.size() == 0 && !in_tvalid)) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && rsp_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sist_pkg.sv
design/sist_ram.sv
design/sorted_id_set_table_core.sv
dv/sorted_id_set_table_core_test.sv
